FILE: src/mlpq_pkg.sv
`default_nettype none
package mlpq_pkg;

  localparam int FUNC_W = 2;
  localparam int STAT_W = 2;
  localparam int DATA_W = 32;
  localparam int PRIO_W = 8;

  localparam logic [FUNC_W-1:0] FUNC_ENQ      = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_DEQ_EXACT = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_DEQ_MIN  = 2'd2;

  localparam logic [STAT_W-1:0] ST_DEQ  = 2'd0;
  localparam logic [STAT_W-1:0] ST_NONE = 2'd1;
  localparam logic [STAT_W-1:0] ST_ENQ  = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd3;

  // level search works on groups of this many levels
  localparam int GRP_W = 16;

endpackage
`default_nettype wire

FILE: src/multilevel_priority_queue.sv
`default_nettype none
// channel  dir  tdata                              tuser
// s_axis   in   [31:0] data, [39:32] priority_req  [1:0] func
// m_axis   out  [31:0] data_out, [39:32] level_out [1:0] status
//
// Dequeue at or above a level runs group search, pick, head read, slot read
// and write back in turn. When the result register is still occupied the
// item waits in HOLD until m_axis frees it. The pointer and slot memories
// have registered reads.
// Reset clears the level valid bits and counters; no clearing pass.
// One item is in flight at a time; a finished result may wait at m_axis
// while the next item is taken.
module multilevel_priority_queue #(
  parameter int LEVELS   = 256,
  parameter int CAPACITY = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,   // data, priority_req
  input  wire logic [1:0]  s_tuser,   // func
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,   // data_out, level_out
  output logic [1:0]       m_tuser    // status
);

  localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int GW = mlpq_pkg::GRP_W;
  localparam int NG = (LEVELS + GW - 1) / GW;
  localparam int XW = LW + mlpq_pkg::PRIO_W;

  typedef enum logic [2:0] {IDLE, ENQ, SRCH, PICK, DREAD, POP, HOLD} state_t;

  state_t state;

  logic [31:0] slot_data [CAPACITY];
  logic [SW-1:0] slot_next [CAPACITY];
  logic [SW-1:0] level_head [LEVELS];
  logic [SW-1:0] level_tail [LEVELS];

  logic [LEVELS-1:0] nonempty;
  logic [SW-1:0] free_head;
  logic [CW-1:0] used;
  logic [CW-1:0] fresh;

  logic [LW-1:0] lvl;
  logic [31:0] word;
  logic [mlpq_pkg::PRIO_W-1:0] req;
  logic [SW-1:0] head_rd, tail_rd, next_rd;
  logic [31:0] data_rd;
  logic [NG-1:0] grp_any;
  logic [NG-1:0] grp_or;
  logic [1:0] pend_status;
  logic [31:0] pend_data;
  logic [7:0] pend_level;

  logic accept;
  logic [XW-1:0] in_ext, req_ext;
  logic [LW-1:0] in_idx;
  logic in_range;
  logic [LEVELS-1:0] masked;
  logic found;
  logic [LW-1:0] pick_idx;
  logic [LW-1:0] lvl_addr;
  logic [SW-1:0] slot_addr;
  logic [SW-1:0] enq_slot;
  logic out_free;
  logic load;
  logic fin;
  logic [1:0] fin_status;
  logic [31:0] fin_data;
  logic [XW-1:0] lvl_ext;

  assign s_tready = (state == IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign load     = out_free && (fin || state == HOLD);

  assign in_ext   = {{LW{1'b0}}, s_tdata[39:32]};
  assign in_idx   = in_ext[LW-1:0];
  assign in_range = in_ext < XW'(LEVELS);
  assign req_ext  = {{LW{1'b0}}, req};
  assign lvl_ext  = {{mlpq_pkg::PRIO_W{1'b0}}, lvl};

  assign enq_slot = (fresh != used) ? free_head : fresh[SW-1:0];

  always_comb begin
    for (int l = 0; l < LEVELS; l++) begin
      masked[l] = nonempty[l] && (XW'(l) >= req_ext);
    end
  end

  // first stage of the search: one flag per group of levels
  always_comb begin
    grp_or = '0;
    for (int k = 0; k < NG; k++) begin
      for (int j = 0; j < GW; j++) begin
        if (k * GW + j < LEVELS) begin
          if (masked[k * GW + j]) grp_or[k] = 1'b1;
        end
      end
    end
  end

  // second stage of the search: highest group, then highest level in it
  always_comb begin
    int g;
    g = 0;
    found = 1'b0;
    pick_idx = '0;
    for (int k = 0; k < NG; k++) begin
      if (grp_any[k]) begin
        g = k;
        found = 1'b1;
      end
    end
    for (int j = 0; j < GW; j++) begin
      if (g * GW + j < LEVELS) begin
        if (masked[g * GW + j]) pick_idx = LW'(g * GW + j);
      end
    end
  end

  always_comb begin
    if (state == IDLE) lvl_addr = in_idx;
    else if (state == PICK) lvl_addr = pick_idx;
    else lvl_addr = lvl;
    slot_addr = (state == DREAD) ? head_rd : free_head;
  end

  always_comb begin
    fin = 1'b0;
    fin_status = mlpq_pkg::ST_NONE;
    fin_data = '0;
    unique case (state)
      ENQ: begin
        fin = 1'b1;
        fin_status = mlpq_pkg::ST_ENQ;
      end
      POP: begin
        fin = 1'b1;
        fin_status = mlpq_pkg::ST_DEQ;
        fin_data = data_rd;
      end
      default: fin = 1'b0;
    endcase
  end

  // memories
  always_ff @(posedge clk) begin
    if (state == ENQ) slot_data[enq_slot] <= word;
    data_rd <= slot_data[slot_addr];
  end

  always_ff @(posedge clk) begin
    if (state == ENQ && nonempty[lvl]) slot_next[tail_rd] <= enq_slot;
    else if (state == POP) slot_next[head_rd] <= free_head;
    next_rd <= slot_next[slot_addr];
  end

  always_ff @(posedge clk) begin
    if (state == ENQ && !nonempty[lvl]) level_head[lvl] <= enq_slot;
    else if (state == POP && head_rd != tail_rd) level_head[lvl] <= next_rd;
    head_rd <= level_head[lvl_addr];
  end

  always_ff @(posedge clk) begin
    if (state == ENQ) level_tail[lvl] <= enq_slot;
    tail_rd <= level_tail[lvl_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      nonempty  <= '0;
      free_head <= '0;
      used      <= '0;
      fresh     <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      if (load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      unique case (state)
        IDLE: begin
          if (accept) begin
            word <= s_tdata[31:0];
            req  <= s_tdata[39:32];
            lvl  <= in_idx;
            pend_status <= mlpq_pkg::ST_NONE;
            pend_data   <= '0;
            pend_level  <= '0;
            priority case (s_tuser)
              mlpq_pkg::FUNC_ENQ: begin
                if (in_range && used != CW'(CAPACITY)) state <= ENQ;
                else begin
                  pend_status <= mlpq_pkg::ST_FULL;
                  state <= HOLD;
                end
              end
              mlpq_pkg::FUNC_DEQ_EXACT: begin
                if (in_range && nonempty[in_idx]) state <= DREAD;
                else state <= HOLD;
              end
              mlpq_pkg::FUNC_DEQ_MIN: state <= SRCH;
              default: state <= HOLD;
            endcase
          end
        end
        ENQ: begin
          nonempty[lvl] <= 1'b1;
          used <= used + 1'b1;
          if (fresh != used) free_head <= next_rd;
          else fresh <= fresh + 1'b1;
        end
        SRCH: begin
          grp_any <= grp_or;
          state <= PICK;
        end
        PICK: begin
          lvl <= pick_idx;
          state <= found ? DREAD : HOLD;
        end
        DREAD: state <= POP;
        POP: begin
          if (head_rd == tail_rd) nonempty[lvl] <= 1'b0;
          free_head <= head_rd;
          used <= used - 1'b1;
        end
        HOLD: begin
          if (out_free) begin
            m_tuser  <= pend_status;
            m_tdata  <= {pend_level, pend_data};
            state    <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
      if (fin) begin
        if (out_free) begin
          m_tuser  <= fin_status;
          m_tdata  <= {(state == POP) ? lvl_ext[7:0] : 8'd0, fin_data};
          state    <= IDLE;
        end else begin
          pend_status <= fin_status;
          pend_data   <= fin_data;
          pend_level  <= (state == POP) ? lvl_ext[7:0] : 8'd0;
          state       <= HOLD;
        end
      end
    end
  end

endmodule
`default_nettype wire

FILE: tb/multilevel_priority_queue_tb.sv
`timescale 1ns / 1ps
module multilevel_priority_queue_tb;

  localparam int NUM_LEVELS = 256;
  localparam int POOL_SIZE  = 1024;
  localparam int PW = mlpq_pkg::PRIO_W;
  localparam logic [mlpq_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  typedef struct packed {
    logic                        hold;   // wait for all results before offering
    logic [mlpq_pkg::FUNC_W-1:0] func;
    logic [mlpq_pkg::DATA_W-1:0] data;
    logic [mlpq_pkg::PRIO_W-1:0] prio;
  } op_t;

  typedef struct packed {
    logic [mlpq_pkg::STAT_W-1:0] status;
    logic [mlpq_pkg::DATA_W-1:0] data;
    logic [mlpq_pkg::PRIO_W-1:0] level;
  } answer_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;  // data, priority_req
  logic [1:0]  s_tuser = '0;  // func
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;       // data_out, level_out
  logic [1:0]  m_tuser;       // status

  op_t         ops_pending[$];
  op_t         cur_op;
  answer_t     answers_due[$];
  logic [mlpq_pkg::DATA_W-1:0] level_fifo[NUM_LEVELS][$];
  int          pool_used = 0;
  int          errors = 0;

  multilevel_priority_queue i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic answer_t pop_level(int lvl);
    answer_t a;
    a.status = mlpq_pkg::ST_DEQ;
    a.data   = level_fifo[lvl].pop_front();
    a.level  = lvl[PW-1:0];
    pool_used--;
    return a;
  endfunction

  function automatic answer_t queue_answer(op_t op);
    answer_t a;
    a = '{mlpq_pkg::ST_NONE, '0, '0};
    case (op.func)
      mlpq_pkg::FUNC_ENQ: begin
        if (pool_used >= POOL_SIZE) begin
          a.status = mlpq_pkg::ST_FULL;
        end else begin
          level_fifo[op.prio].push_back(op.data);
          pool_used++;
          a.status = mlpq_pkg::ST_ENQ;
        end
      end
      mlpq_pkg::FUNC_DEQ_EXACT: begin
        if (level_fifo[op.prio].size() != 0) a = pop_level(op.prio);
      end
      mlpq_pkg::FUNC_DEQ_MIN: begin
        for (int i = NUM_LEVELS - 1; i >= int'(op.prio); i--) begin
          if (level_fifo[i].size() != 0) begin
            a = pop_level(i);
            break;
          end
        end
      end
      default: ;
    endcase
    return a;
  endfunction

  // driver: bursts with random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    logic next_valid;
    if (!rst) begin
      next_valid = s_tvalid;
      if (s_tvalid && s_tready) begin
        answers_due.push_back(queue_answer(cur_op));
        next_valid = 1'b0;
      end
      if (!s_tvalid || s_tready) begin
        next_valid = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (ops_pending.size() != 0 &&
                     !(ops_pending[0].hold && answers_due.size() != 0)) begin
          cur_op = ops_pending.pop_front();
          s_tdata <= {cur_op.prio, cur_op.data};
          s_tuser <= cur_op.func;
          next_valid = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(50, 200)
                                                   : $urandom_range(1, 20);
            gap_left = $urandom_range(1, 8);
          end
        end
      end
      s_tvalid <= next_valid;
    end
  end

  // receiver stall pattern, with one long hold-off
  int rx_cycle = 0;
  always @(posedge clk) begin
    if (!rst) begin
      rx_cycle++;
      if (rx_cycle >= 2500 && rx_cycle < 4000)
        m_tready <= 1'b0;
      else if ((rx_cycle / 300) % 3 == 0)
        m_tready <= 1'b1;
      else
        m_tready <= ($urandom_range(0, 3) != 0);
    end
  end

  // monitor
  always @(posedge clk) begin
    answer_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (answers_due.size() == 0) begin
        $display("%0t: unexpected result status=%0d data=%h level=%0d",
                 $time, m_tuser, m_tdata[31:0], m_tdata[39:32]);
        errors++;
      end else begin
        want = answers_due.pop_front();
        if (m_tuser !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, m_tuser);
          errors++;
        end
        if (m_tdata[31:0] !== want.data) begin
          $display("%0t: data_out expected %h actual %h", $time, want.data, m_tdata[31:0]);
          errors++;
        end
        if (m_tdata[39:32] !== want.level) begin
          $display("%0t: level_out expected %0d actual %0d", $time, want.level,
                   m_tdata[39:32]);
          errors++;
        end
      end
    end
  end

  task automatic add_op(logic [mlpq_pkg::FUNC_W-1:0] f, logic [mlpq_pkg::DATA_W-1:0] d,
                        logic [mlpq_pkg::PRIO_W-1:0] p, logic h = 1'b0);
    ops_pending.push_back('{h, f, d, p});
  endtask

  function automatic logic [mlpq_pkg::PRIO_W-1:0] pick_level();
    return ($urandom_range(0, 4) == 0) ? PW'($urandom_range(0, 255))
                                       : PW'($urandom_range(0, 7));
  endfunction

  initial begin
    int r;
    // directed
    add_op(mlpq_pkg::FUNC_DEQ_EXACT, '0, 8'd0);
    add_op(mlpq_pkg::FUNC_DEQ_MIN, '0, 8'd0);
    add_op(mlpq_pkg::FUNC_ENQ, 32'h8000_0000, 8'd255);
    add_op(mlpq_pkg::FUNC_ENQ, 32'h7fff_ffff, 8'd0);
    add_op(mlpq_pkg::FUNC_ENQ, 32'hffff_ffff, 8'd128);
    add_op(mlpq_pkg::FUNC_ENQ, 32'h0000_0000, 8'd128);
    add_op(mlpq_pkg::FUNC_ENQ, 32'h5555_aaaa, 8'd255);
    add_op(FUNC_UNUSED, 32'hffff_ffff, 8'hff);
    add_op(mlpq_pkg::FUNC_DEQ_EXACT, '0, 8'd1);
    add_op(mlpq_pkg::FUNC_DEQ_MIN, '0, 8'd129);
    add_op(mlpq_pkg::FUNC_DEQ_EXACT, '0, 8'd255);
    add_op(mlpq_pkg::FUNC_DEQ_MIN, '0, 8'd200);
    add_op(mlpq_pkg::FUNC_DEQ_MIN, '0, 8'd200);
    add_op(mlpq_pkg::FUNC_DEQ_MIN, '0, 8'd0);
    add_op(mlpq_pkg::FUNC_DEQ_EXACT, '0, 8'd128);
    add_op(mlpq_pkg::FUNC_DEQ_MIN, '0, 8'd0);
    add_op(mlpq_pkg::FUNC_DEQ_MIN, '0, 8'd0);
    // fill the pool until it refuses, then drain part of it from the top
    for (int i = 0; i < POOL_SIZE + 6; i++)
      add_op(mlpq_pkg::FUNC_ENQ, $urandom, pick_level(), i == 0);
    add_op(mlpq_pkg::FUNC_DEQ_MIN, '0, 8'd0, 1'b1);
    add_op(mlpq_pkg::FUNC_ENQ, $urandom, 8'd3);
    add_op(mlpq_pkg::FUNC_ENQ, $urandom, 8'd3);
    for (int i = 0; i < 300; i++)
      add_op(mlpq_pkg::FUNC_DEQ_MIN, '0, 8'd0);
    // random phases: enqueue-heavy, then dequeue-heavy
    for (int ph = 0; ph < 6; ph++) begin
      for (int i = 0; i < 100; i++) begin
        r = $urandom_range(0, 99);
        if (r < ((ph % 2 == 0) ? 70 : 25))
          add_op(mlpq_pkg::FUNC_ENQ, $urandom, pick_level(), i == 0 && ph == 4);
        else if (r < 97)
          add_op(r % 2 ? mlpq_pkg::FUNC_DEQ_EXACT : mlpq_pkg::FUNC_DEQ_MIN, $urandom,
                 pick_level());
        else
          add_op(FUNC_UNUSED, $urandom, pick_level());
      end
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    while (ops_pending.size() != 0 || s_tvalid || answers_due.size() != 0)
      @(posedge clk);
    repeat (30) @(posedge clk);
    if (errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #5ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
